// ----- hw/rtl/alx_pkg.sv -----
// Shared types, token codes and character codes of the expression lexer.
`default_nettype none

package alx_pkg;

    localparam int POS_BITS   = 16;
    localparam int ACC_BITS   = 31;
    localparam int FRAC_BITS  = 5;
    localparam int KIND_BITS  = 4;
    localparam int CHAR_BITS  = 8;
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int RES_N_BITS = $clog2(MAX_RES + 1);

    localparam logic [ACC_BITS-1:0]  ACC_MAX  = {ACC_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

    localparam logic [KIND_BITS-1:0] KIND_INT     = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_FLOAT   = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_PLUS    = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_MINUS   = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_MUL     = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_DIV     = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_MOD     = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_BADCHAR = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_BADNUM  = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_END     = 4'd11;

    localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_MOD    = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_MUL    = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_DIV    = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_DIG0   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_DIG9   = 8'h39;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ACC_BITS-1:0]  int_value;
        logic [FRAC_BITS-1:0] frac_digits;
        logic                 overflow;
        logic [POS_BITS-1:0]  start_pos;
        logic [POS_BITS-1:0]  end_pos;
        logic [CHAR_BITS-1:0] bad_char;
        logic                 last_of_run;
    } token_t;

    typedef struct packed {
        logic                 in_number;
        logic [1:0]           dot_count;
        logic [ACC_BITS-1:0]  number_accum;
        logic [FRAC_BITS-1:0] frac_count;
        logic [POS_BITS-1:0]  number_start;
        logic [POS_BITS-1:0]  byte_index;
        logic                 halted;
        logic                 sat_flag;
    } lex_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/alx_step.sv -----
// Per-byte lexer step: next scan state and up to three packed result tokens.
`default_nettype none

module alx_step (
    input  wire logic [alx_pkg::CHAR_BITS-1:0]  char_code,
    input  wire logic                           last_char,
    input  wire alx_pkg::lex_state_t            st,
    output alx_pkg::lex_state_t                 st_next,
    output alx_pkg::token_t                     res [alx_pkg::MAX_RES],
    output logic [alx_pkg::RES_N_BITS-1:0]      res_n
);

    function automatic alx_pkg::token_t finish_tok(
        input alx_pkg::lex_state_t s,
        input logic [alx_pkg::POS_BITS-1:0] e
    );
        alx_pkg::token_t t;
        t = '0;
        t.start_pos = s.number_start;
        t.end_pos   = e;
        if (s.dot_count >= 2'd2) begin
            t.kind = alx_pkg::KIND_BADNUM;
        end else if (s.dot_count == 2'd1) begin
            t.kind        = alx_pkg::KIND_FLOAT;
            t.int_value   = s.number_accum;
            t.frac_digits = s.frac_count;
            t.overflow    = s.sat_flag;
        end else begin
            t.kind      = alx_pkg::KIND_INT;
            t.int_value = s.number_accum;
            t.overflow  = s.sat_flag;
        end
        return t;
    endfunction

    logic [alx_pkg::POS_BITS-1:0] idx, nxt;
    logic is_digit, is_dot, is_zero, is_ws, is_op, is_bad;
    logic [alx_pkg::KIND_BITS-1:0] op_kind;
    logic [3:0] digit_val;
    logic [alx_pkg::ACC_BITS+3:0] acc_prod;
    logic cont, a_v, skip, b_v, c_v, d_v, start_num, final_en, halt_n, in_num_n;
    alx_pkg::lex_state_t upd;
    alx_pkg::token_t tok_a, tok_b, tok_c, tok_d;
    alx_pkg::token_t cand [alx_pkg::MAX_RES];
    logic [alx_pkg::MAX_RES-1:0] cand_v;
    logic [alx_pkg::RES_N_BITS-1:0] cnt;

    assign idx       = st.byte_index;
    assign nxt       = st.byte_index + 1'b1;
    assign is_digit  = (char_code >= alx_pkg::CH_DIG0) && (char_code <= alx_pkg::CH_DIG9);
    assign is_dot    = (char_code == alx_pkg::CH_DOT);
    assign is_zero   = (char_code == alx_pkg::CH_NUL);
    assign is_ws     = (char_code == alx_pkg::CH_SPACE) || (char_code == alx_pkg::CH_TAB)
                    || (char_code == alx_pkg::CH_NL);
    assign digit_val = 4'(char_code - alx_pkg::CH_DIG0);

    always_comb
    begin
        is_op   = 1'b1;
        op_kind = alx_pkg::KIND_PLUS;
        case (char_code)
            alx_pkg::CH_PLUS:   op_kind = alx_pkg::KIND_PLUS;
            alx_pkg::CH_MINUS:  op_kind = alx_pkg::KIND_MINUS;
            alx_pkg::CH_MUL:    op_kind = alx_pkg::KIND_MUL;
            alx_pkg::CH_DIV:    op_kind = alx_pkg::KIND_DIV;
            alx_pkg::CH_MOD:    op_kind = alx_pkg::KIND_MOD;
            alx_pkg::CH_LPAREN: op_kind = alx_pkg::KIND_LPAREN;
            alx_pkg::CH_RPAREN: op_kind = alx_pkg::KIND_RPAREN;
            default:            is_op   = 1'b0;
        endcase
    end

    assign is_bad = !is_digit && !is_op && !is_ws && !is_zero;

    // accum * 10 + digit, checked against the saturation limit
    assign acc_prod = ({4'b0, st.number_accum} << 3) + ({4'b0, st.number_accum} << 1)
                    + {{(alx_pkg::ACC_BITS){1'b0}}, digit_val};

    assign cont      = st.in_number && (is_digit || is_dot);
    assign a_v       = !st.halted && st.in_number && !cont;
    assign skip      = a_v && (st.dot_count >= 2'd2);
    assign b_v       = !st.halted && !cont && !skip && (is_zero || is_op || is_bad);
    assign start_num = !st.halted && !cont && !skip && is_digit;
    assign halt_n    = st.halted || skip || (b_v && (is_zero || is_bad));
    assign in_num_n  = !st.halted && (cont || start_num);
    assign final_en  = !st.halted && !is_zero && last_char && !halt_n;

    always_comb
    begin
        upd              = st;
        upd.byte_index   = nxt;
        upd.halted       = halt_n;
        upd.in_number    = in_num_n;
        if (cont && is_dot) begin
            if (st.dot_count < 2'd2)
                upd.dot_count = st.dot_count + 2'd1;
        end else if (cont) begin
            if (acc_prod > {4'b0, alx_pkg::ACC_MAX}) begin
                upd.number_accum = alx_pkg::ACC_MAX;
                upd.sat_flag     = 1'b1;
            end else begin
                upd.number_accum = acc_prod[alx_pkg::ACC_BITS-1:0];
            end
            if (st.dot_count >= 2'd1) begin
                if (st.frac_count >= alx_pkg::FRAC_MAX)
                    upd.sat_flag = 1'b1;
                else
                    upd.frac_count = st.frac_count + 1'b1;
            end
        end else if (start_num) begin
            upd.number_accum = {{(alx_pkg::ACC_BITS-4){1'b0}}, digit_val};
            upd.dot_count    = 2'd0;
            upd.frac_count   = '0;
            upd.number_start = idx;
            upd.sat_flag     = 1'b0;
        end
        st_next = last_char ? alx_pkg::lex_state_t'('0) : upd;
    end

    assign c_v = final_en && in_num_n;
    assign d_v = final_en && !(c_v && (upd.dot_count >= 2'd2));

    always_comb
    begin
        tok_a = finish_tok(st, idx);
        tok_c = finish_tok(upd, nxt);

        tok_b           = '0;
        tok_b.start_pos = idx;
        tok_b.end_pos   = nxt;
        if (is_zero) begin
            tok_b.kind    = alx_pkg::KIND_END;
            tok_b.end_pos = idx;
        end else if (is_op) begin
            tok_b.kind = op_kind;
        end else begin
            tok_b.kind     = alx_pkg::KIND_BADCHAR;
            tok_b.bad_char = char_code;
        end

        tok_d           = '0;
        tok_d.kind      = alx_pkg::KIND_END;
        tok_d.start_pos = nxt;
        tok_d.end_pos   = nxt;
    end

    // the operator token and the closing number never occur together
    assign cand[0] = tok_a;
    assign cand[1] = b_v ? tok_b : tok_c;
    assign cand[2] = tok_d;
    assign cand_v  = {d_v, b_v || c_v, a_v};

    always_comb
    begin
        for (int i = 0; i < alx_pkg::MAX_RES; i++)
            res[i] = '0;
        cnt = '0;
        for (int i = 0; i < alx_pkg::MAX_RES; i++) begin
            if (cand_v[i]) begin
                res[cnt[1:0]] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        if (cnt != '0)
            res[2'(cnt - 1'b1)].last_of_run = 1'b1;
        res_n = cnt;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/alx_result_fifo.sv -----
// Small result queue: takes up to three tokens a cycle while room is high, hands out one while head_ready is high.
`default_nettype none

module alx_result_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [alx_pkg::RES_N_BITS-1:0] push_n,
    input  wire alx_pkg::token_t                push_data [alx_pkg::MAX_RES],
    output logic                                room,
    output logic                                head_valid,
    input  wire logic                           head_ready,
    output alx_pkg::token_t                     head
);

    localparam int PTR_BITS = $clog2(alx_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(alx_pkg::FIFO_DEPTH + 1);
    localparam int RES_N_W  = alx_pkg::RES_N_BITS;

    alx_pkg::token_t mem [alx_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign room       = (count_reg <= CNT_BITS'(alx_pkg::FIFO_DEPTH - alx_pkg::MAX_RES));

    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < alx_pkg::MAX_RES; i++) begin
            if (RES_N_W'(i) < push_n)
                mem[wr_ptr_reg + PTR_BITS'(i)] <= push_data[i];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(alx_pkg::FIFO_DEPTH))
        else $error("result queue count above depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != '0) |-> room)
        else $error("tokens pushed without room for a full run");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_BITS'(alx_pkg::FIFO_DEPTH))
        || (PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_BITS-1:0]))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hw/rtl/arith_expression_lexer_core.sv -----
// Top level of the arithmetic expression lexer: input stage, scan state, result queue.
//
//  channel | handshake              | word
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid / in_ready    | char_code, last_char
//  out     | out_valid / out_ready  | token_kind, int_value, frac_digits, overflow,
//          |                        | start_pos, end_pos, bad_char, last_of_run
//
//  One input word per cycle while words make at most one token each and out_ready is
//  high; a word enters the input register, and once the queue has room the step logic
//  (multiply by ten plus add) writes its 0..3 tokens to the queue. A word is stepped only
//  while the four-entry queue holds at most one token, so after a word that makes three
//  tokens the next word waits while the queue drains. Tokens leave one per cycle while
//  out_ready is high; the first is offered once its word's tokens are in the queue.
//  Reset clears scan state, input stage and queue; there is no clearing pass.
`default_nettype none

module arith_expression_lexer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [alx_pkg::CHAR_BITS-1:0] char_code,
    input  wire logic                          last_char,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [alx_pkg::KIND_BITS-1:0]      token_kind,
    output logic [alx_pkg::ACC_BITS-1:0]       int_value,
    output logic [alx_pkg::FRAC_BITS-1:0]      frac_digits,
    output logic                               overflow,
    output logic [alx_pkg::POS_BITS-1:0]       start_pos,
    output logic [alx_pkg::POS_BITS-1:0]       end_pos,
    output logic [alx_pkg::CHAR_BITS-1:0]      bad_char,
    output logic                               last_of_run
);

    logic                          in_v_reg, in_v_next;
    logic [alx_pkg::CHAR_BITS-1:0] char_reg;
    logic                          last_reg;
    alx_pkg::lex_state_t           st_reg, st_next;
    alx_pkg::token_t               res [alx_pkg::MAX_RES];
    logic [alx_pkg::RES_N_BITS-1:0] res_n, push_n;
    logic                          room, step_fire;
    alx_pkg::token_t               head;

    assign step_fire = in_v_reg && room;
    assign in_ready  = !in_v_reg || step_fire;
    assign push_n    = step_fire ? res_n : '0;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_valid && in_ready)
            in_v_next = 1'b1;
        else if (step_fire)
            in_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_v_reg <= 1'b0;
            st_reg   <= '0;
        end else begin
            in_v_reg <= in_v_next;
            if (step_fire)
                st_reg <= st_next;
        end
    end

    // hold the word until it is stepped
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    alx_step u_step (
        .char_code (char_reg),
        .last_char (last_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .res       (res),
        .res_n     (res_n)
    );

    alx_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_data  (res),
        .room       (room),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign token_kind  = head.kind;
    assign int_value   = head.int_value;
    assign frac_digits = head.frac_digits;
    assign overflow    = head.overflow;
    assign start_pos   = head.start_pos;
    assign end_pos     = head.end_pos;
    assign bad_char    = head.bad_char;
    assign last_of_run = head.last_of_run;

    a_halt_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.halted |-> !st_reg.in_number)
        else $error("halted stream still holds a number");

    a_dot_sat: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.dot_count != 2'd3)
        else $error("dot count past saturation");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && st_reg.halted && !last_reg) |=> st_reg.halted)
        else $error("halted stream resumed before its final byte");

    a_halt_no_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && st_reg.halted) |-> (push_n == '0))
        else $error("tokens produced while halted");

endmodule

`default_nettype wire

// ----- tb/sv/lexer_check_pkg.sv -----
// Token predictor and scoreboard for the arithmetic expression lexer.
package lexer_check_pkg;

    import alx_pkg::*;

    class lexer_scoreboard;

        token_t     expected_tokens[$];
        lex_state_t scan;
        int         mismatch_count;
        int         tokens_checked;

        function new();
            scan = '0;
            mismatch_count = 0;
            tokens_checked = 0;
        endfunction

        function void push_token(logic [KIND_BITS-1:0] kind, logic [ACC_BITS-1:0] value,
                                 logic [FRAC_BITS-1:0] frac, logic ovf,
                                 logic [POS_BITS-1:0] from_pos, logic [POS_BITS-1:0] to_pos,
                                 logic [CHAR_BITS-1:0] code);
            token_t tok;
            tok.kind        = kind;
            tok.int_value   = value;
            tok.frac_digits = frac;
            tok.overflow    = ovf;
            tok.start_pos   = from_pos;
            tok.end_pos     = to_pos;
            tok.bad_char    = code;
            tok.last_of_run = 1'b0;
            expected_tokens = {expected_tokens, tok};
        endfunction

        // Close the open number at to_pos; returns 1 when it had too many dots.
        function bit end_number(logic [POS_BITS-1:0] to_pos);
            scan.in_number = 1'b0;
            if (scan.dot_count >= 2)
            begin
                push_token(KIND_BADNUM, '0, '0, 1'b0, scan.number_start, to_pos, '0);
                return 1'b1;
            end
            if (scan.dot_count == 1)
            begin
                push_token(KIND_FLOAT, scan.number_accum, scan.frac_count, scan.sat_flag,
                           scan.number_start, to_pos, '0);
            end
            else
            begin
                push_token(KIND_INT, scan.number_accum, '0, scan.sat_flag,
                           scan.number_start, to_pos, '0);
            end
            return 1'b0;
        endfunction

        // Step the predictor with one accepted input word.
        function void note_byte(logic [CHAR_BITS-1:0] code, logic is_last);
            logic [POS_BITS-1:0]  idx;
            logic [POS_BITS-1:0]  nxt;
            logic                 digit;
            logic                 dot;
            logic                 skip;
            bit                   bad;
            int unsigned          d;
            int                   prior;
            logic [KIND_BITS-1:0] op_kind;
            prior = expected_tokens.size();
            idx   = scan.byte_index;
            nxt   = idx + 1'b1;
            digit = (code >= CH_DIG0) && (code <= CH_DIG9);
            dot   = (code == CH_DOT);
            bad   = 1'b0;
            if (scan.halted)
            begin
                // drop everything until the final byte
            end
            else if (code == CH_NUL)
            begin
                if (scan.in_number)
                    bad = end_number(idx);
                if (!bad)
                    push_token(KIND_END, '0, '0, 1'b0, idx, idx, '0);
                scan.halted = 1'b1;
            end
            else if (scan.in_number && (digit || dot))
            begin
                if (dot)
                begin
                    if (scan.dot_count < 2)
                        scan.dot_count++;
                end
                else
                begin
                    d = code - CH_DIG0;
                    if (scan.number_accum > (ACC_MAX - d) / 10)
                    begin
                        scan.number_accum = ACC_MAX;
                        scan.sat_flag = 1'b1;
                    end
                    else
                    begin
                        scan.number_accum = scan.number_accum * 10 + d;
                    end
                    if (scan.dot_count != 0)
                    begin
                        if (scan.frac_count == FRAC_MAX)
                            scan.sat_flag = 1'b1;
                        else
                            scan.frac_count++;
                    end
                end
            end
            else
            begin
                if (scan.in_number)
                    bad = end_number(idx);
                if (bad)
                begin
                    // the byte that closed a bad number is dropped
                    scan.halted = 1'b1;
                end
                else if (digit)
                begin
                    scan.in_number    = 1'b1;
                    scan.number_accum = code - CH_DIG0;
                    scan.dot_count    = '0;
                    scan.frac_count   = '0;
                    scan.number_start = idx;
                    scan.sat_flag     = 1'b0;
                end
                else
                begin
                    skip = 1'b0;
                    case (code)
                        CH_PLUS:   op_kind = KIND_PLUS;
                        CH_MINUS:  op_kind = KIND_MINUS;
                        CH_MUL:    op_kind = KIND_MUL;
                        CH_DIV:    op_kind = KIND_DIV;
                        CH_MOD:    op_kind = KIND_MOD;
                        CH_LPAREN: op_kind = KIND_LPAREN;
                        CH_RPAREN: op_kind = KIND_RPAREN;
                        CH_SPACE, CH_TAB, CH_NL:
                        begin
                            op_kind = KIND_END;
                            skip = 1'b1;
                        end
                        default:   op_kind = KIND_BADCHAR;
                    endcase
                    if (!skip)
                    begin
                        push_token(op_kind, '0, '0, 1'b0, idx, nxt,
                                   (op_kind == KIND_BADCHAR) ? code : '0);
                        if (op_kind == KIND_BADCHAR)
                            scan.halted = 1'b1;
                    end
                end
            end
            scan.byte_index = nxt;
            if (is_last && !scan.halted)
            begin
                bad = 1'b0;
                if (scan.in_number)
                    bad = end_number(nxt);
                if (!bad)
                    push_token(KIND_END, '0, '0, 1'b0, nxt, nxt, '0);
            end
            if (is_last)
                scan = '0;
            if (expected_tokens.size() > prior)
                expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
        endfunction

        task report(string msg);
            mismatch_count++;
            $display("[%0t] MISMATCH %s", $realtime, msg);
        endtask

        task compare_field(string field, longint unsigned got, longint unsigned want);
            if (got != want)
                report($sformatf("token %0d %s: got %0d, expected %0d",
                                 tokens_checked, field, got, want));
        endtask

        task check_token(token_t got);
            token_t want;
            tokens_checked++;
            if (expected_tokens.size() == 0)
            begin
                report($sformatf("token %0d: kind %0d arrived with nothing expected",
                                 tokens_checked, got.kind));
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("token_kind", got.kind, want.kind);
            compare_field("int_value", got.int_value, want.int_value);
            compare_field("frac_digits", got.frac_digits, want.frac_digits);
            compare_field("overflow", got.overflow, want.overflow);
            compare_field("start_pos", got.start_pos, want.start_pos);
            compare_field("end_pos", got.end_pos, want.end_pos);
            compare_field("bad_char", got.bad_char, want.bad_char);
            compare_field("last_of_run", got.last_of_run, want.last_of_run);
        endtask

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top level of the lexer testbench: clock, reset, drivers, monitor and watchdog.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import alx_pkg::*;
    import lexer_check_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 100;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
    logic                 out_valid;
    logic                 out_ready;
    logic [KIND_BITS-1:0] token_kind;
    logic [ACC_BITS-1:0]  int_value;
    logic [FRAC_BITS-1:0] frac_digits;
    logic                 overflow;
    logic [POS_BITS-1:0]  start_pos;
    logic [POS_BITS-1:0]  end_pos;
    logic [CHAR_BITS-1:0] bad_char;
    logic                 last_of_run;

    bit                   calm = 1'b0;
    bit                   hold_request = 1'b0;
    int                   sent_items = 0;
    logic [CHAR_BITS-1:0] text[$];
    lexer_scoreboard      sb;

    arith_expression_lexer_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_kind (token_kind),
        .int_value  (int_value),
        .frac_digits(frac_digits),
        .overflow   (overflow),
        .start_pos  (start_pos),
        .end_pos    (end_pos),
        .bad_char   (bad_char),
        .last_of_run(last_of_run)
    );

    always #HALF_PERIOD clk = ~clk;

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_byte(logic [CHAR_BITS-1:0] code, logic is_last);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = code;
        last_char = is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        sb.note_byte(code, is_last);
        @(negedge clk);
    endtask

    task automatic send_string(string s, logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    function automatic void append_char(logic [CHAR_BITS-1:0] code);
        text = {text, code};
    endfunction

    function automatic logic [CHAR_BITS-1:0] random_digit();
        return CH_DIG0 + CHAR_BITS'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_BITS-1:0] random_operator();
        case ($urandom_range(0, 6))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            4:       return CH_MOD;
            5:       return CH_LPAREN;
            default: return CH_RPAREN;
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] random_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] random_fault();
        case ($urandom_range(0, 2))
            0:       return CH_DOT;
            1:       return CH_NUL;
            default: return CHAR_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly short ints and floats; now and then long enough to saturate.
    task automatic append_number();
        int int_len;
        int frac_len;
        int shape;
        int_len = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
        shape = $urandom_range(0, 9);
        repeat (int_len) append_char(random_digit());
        if (shape >= 6)
        begin
            frac_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34)
                                                     : $urandom_range(0, 3);
            append_char(CH_DOT);
            repeat (frac_len) append_char(random_digit());
            // a second dot spoils the number
            if (shape == 9)
            begin
                append_char(CH_DOT);
                if ($urandom_range(0, 1) == 1)
                    append_char(random_digit());
            end
        end
    endtask

    task automatic build_expression();
        text.delete();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: append_number();
                4, 5, 6:    append_char(random_operator());
                7:          append_char(random_blank());
                8:
                begin
                    append_number();
                    append_char(random_blank());
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        append_char(random_fault());
                    else
                        append_char(random_operator());
                end
            endcase
        end
    endtask

    task automatic build_noise();
        text.delete();
        repeat ($urandom_range(1, 6)) append_char(CHAR_BITS'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        bit held;
        bit drained;
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        last_char = 1'b0;
        held      = 1'b0;
        drained   = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // ints, a float, every operator and bracket, a blank, number closed by an operator and by the final byte
        send_string("(1.5+2)*3/4%5-\t6", 1'b1);
        // bad number, the closing byte is dropped
        send_string("1..2+", 1'b1);
        // leading dot
        send_string(".", 1'b1);
        // zero byte closes the number, then all is ignored until the final byte
        send_string("7", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (!held && sent_items >= 100)
            begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            if (!drained && sent_items >= 200)
            begin
                wait_drained();
                drained = 1'b1;
            end
            if (sent_items >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if ($urandom_range(0, 19) < 17)
                build_expression();
            else
                build_noise();
            send_text();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (hold_request)
            begin
                // hold off long enough for the queue and the input stage to fill
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    initial
    begin : monitor
        token_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.kind        = token_kind;
                got.int_value   = int_value;
                got.frac_digits = frac_digits;
                got.overflow    = overflow;
                got.start_pos   = start_pos;
                got.end_pos     = end_pos;
                got.bad_char    = bad_char;
                got.last_of_run = last_of_run;
                sb.check_token(got);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
